[design/ple_pkg.sv]
// Shared constants, codes and control types of the positional list engine.
package ple_pkg;

  localparam int unsigned Depth    = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned PosW     = 6;
  localparam int unsigned CntOutW  = 7;
  localparam int unsigned DataOutW = 32;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_WRITE  = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic [IdxW-1:0]   pos;
    logic              rd_en;
    logic [IdxW-1:0]   rpos;
  } cell_ctrl_t;

endpackage

[design/ple_cell.sv]
// One storage cell of the list: holds a word and trades it with its neighbors.
module ple_cell (
  input  logic                            clk_i,
  input  ple_pkg::cell_ctrl_t             ctrl_i,
  input  logic [ple_pkg::IdxW-1:0]        idx_i,
  input  logic [ple_pkg::DataW-1:0]       word_i,
  input  logic [ple_pkg::DataW-1:0]       left_i,
  input  logic [ple_pkg::DataW-1:0]       right_i,
  output logic [ple_pkg::DataW-1:0]       data_o,
  output logic [ple_pkg::DataW-1:0]       tap_o
);
  import ple_pkg::*;

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  // Insert opens a gap at pos by taking the left neighbor's word in every later cell;
  // remove closes the gap by taking the right neighbor's word from pos onward.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          data_d = left_i;
        end else if (idx_i == ctrl_i.pos) begin
          data_d = word_i;
        end
      end
      CMD_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CMD_WRITE: begin
        if (idx_i == ctrl_i.pos) begin
          data_d = word_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (ctrl_i.rd_en && (idx_i == ctrl_i.rpos)) ? data_q : '0;

endmodule

[design/positional_list_engine.sv]
// Top level of the positional list engine: command decode, count and result register.
//
// The block keeps an ordered list of up to 64 words in a row of cells plus an entry
// count. Each input beat carries one operation (append, insert, remove, replace,
// read or clear) with a position and a data word; each accepted beat yields exactly
// one result beat with the read word, the entry count after the operation and a
// status code (done, position out of range, list full, read of empty list).
// Insert and remove shift every later cell by one place in the same cycle, and each
// result is registered: it appears on the output channel in the cycle after its
// input beat is accepted. The rate is set by the result register: one operation per
// cycle while the receiver keeps out_stall_i low.
// While a result waits under out_stall_i, in_stall_o is raised and the next input
// beat waits; it is taken in the cycle that the pending result leaves.
// Reset (rst_ni low) empties the list and drops any pending result. Cell contents
// are not cleared; positions at or beyond the count are never read.
module positional_list_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       operation_i,
  input  logic [ple_pkg::PosW-1:0]         position_i,
  input  logic [ple_pkg::DataOutW-1:0]     item_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ple_pkg::DataOutW-1:0]     read_data_o,
  output logic [ple_pkg::CntOutW-1:0]      entry_count_o,
  output logic [1:0]                       status_o
);
  import ple_pkg::*;

  logic                 in_fire;
  logic [CntW-1:0]      count_q;
  logic [CntW-1:0]      count_d;
  logic                 out_valid_q;
  logic [DataOutW-1:0]  read_data_q;
  logic [DataOutW-1:0]  read_data_d;
  status_e              status_q;
  status_e              status_d;
  cell_ctrl_t           ctrl;
  op_e                  op;
  logic                 full;
  logic [CmpW-1:0]      pos_ext;
  logic [CmpW-1:0]      cnt_ext;
  logic [DataW-1:0]     word;
  logic [DataW-1:0]     cell_data [Depth];
  logic [DataW-1:0]     cell_tap  [Depth];
  logic [DataW-1:0]     rd_word;

  // A new beat is taken unless a finished result is held back by the receiver.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign op      = op_e'(operation_i);
  assign full    = (count_q == CntW'(Depth));
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign word    = DataW'(item_data_i);

  // Decode the operation into one command for the whole row of cells.
  always_comb begin
    ctrl.cmd   = CMD_HOLD;
    ctrl.pos   = IdxW'(position_i);
    ctrl.rd_en = 1'b0;
    ctrl.rpos  = IdxW'(position_i);
    count_d    = count_q;
    status_d   = ST_DONE;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.cmd = CMD_INSERT;
          ctrl.pos = IdxW'(count_q);
          count_d  = count_q + CntW'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          // A position past the end turns the insert into an append.
          ctrl.cmd = CMD_INSERT;
          ctrl.pos = (pos_ext > cnt_ext) ? IdxW'(count_q) : IdxW'(position_i);
          count_d  = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.cmd = CMD_REMOVE;
          count_d  = count_q - CntW'(1);
        end
      end
      OP_REPLACE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.cmd = CMD_WRITE;
        end
      end
      OP_READ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          // A read past the end returns the last entry.
          ctrl.rd_en = 1'b1;
          ctrl.rpos  = (pos_ext >= cnt_ext) ? IdxW'(count_q - CntW'(1))
                                            : IdxW'(position_i);
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
    if (!in_fire) begin
      ctrl.cmd = CMD_HOLD;
      count_d  = count_q;
    end
  end

  // The row of cells; the first cell's left input is never selected by a valid shift and
  // is tied to the input word; the last cell's right input is tied to its own word.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    if (i == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IdxW'(i)),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // Only the addressed cell drives a nonzero tap, so an OR tree forms the read word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < Depth; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  assign read_data_d = DataOutW'(rd_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_data_q <= read_data_d;
      status_q    <= status_d;
    end
  end

  // The count only moves when a new beat is taken, which also reloads the result,
  // so the live count is the count of the result on display.
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign entry_count_o = CntOutW'(count_q);
  assign status_o      = status_q;

endmodule

[design/ple_checker.sv]
// Port-level checks of the positional list engine, bound to the top level.
module ple_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [2:0]                    operation_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ple_pkg::DataOutW-1:0]  read_data_o,
  input logic [ple_pkg::CntOutW-1:0]   entry_count_o,
  input logic [1:0]                    status_o
);
  import ple_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat gave no result in the next cycle");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i != OP_READ) |=> read_data_o == '0)
    else $error("nonzero read data on a non-read operation");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == CntOutW'(Depth))
    else $error("full status with a count below capacity");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_data_o   (read_data_o),
  .entry_count_o (entry_count_o),
  .status_o      (status_o)
);

[tb/sv/tb_positional_list_engine.sv]
// Self-checking testbench for the positional list engine, with a shadow list as predictor.
module tb_positional_list_engine;
  import ple_pkg::*;

  // Operation codes that the block must treat as no-ops.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int unsigned RandomBeats = 500;
  localparam int unsigned IdlePct     = 27;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [DataOutW-1:0] read_data;
    logic [CntOutW-1:0]  entry_count;
    status_e             status;
  } list_result_t;

  typedef struct {
    logic [2:0]          op;
    logic [PosW-1:0]     pos;
    logic [DataOutW-1:0] data;
    bit                  typed;
    list_result_t        want;
  } vector_t;

  typedef enum {FILL_MODE, DRAIN_MODE, MIX_MODE} traffic_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [2:0]          operation_i = '0;
  logic [PosW-1:0]     position_i = '0;
  logic [DataOutW-1:0] item_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [DataOutW-1:0] read_data_o;
  logic [CntOutW-1:0]  entry_count_o;
  logic [1:0]          status_o;

  // Shadow copy of the list, updated when an operation beat is accepted.
  logic [DataOutW-1:0] list_cells [Depth];
  int unsigned         list_count = 0;
  list_result_t        pending_results [$];
  int unsigned         mismatches = 0;

  bit steady = 1'b0;
  bit hold_req = 1'b0;

  // Directed rows: typed expectations only where they are obvious.
  vector_t directed_rows [19] = '{
    '{OP_READ,    6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, ST_EMPTY}},
    '{OP_REMOVE,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, ST_RANGE}},
    '{OP_REPLACE, 6'd63, 32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd0, ST_RANGE}},
    '{OP_APPEND,  6'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd1, ST_DONE}},
    '{OP_APPEND,  6'd63, 32'h0000_0000, 1'b1, '{32'h0, 7'd2, ST_DONE}},
    '{OP_INSERT,  6'd0,  32'hA5A5_A5A5, 1'b1, '{32'h0, 7'd3, ST_DONE}},
    '{OP_INSERT,  6'd63, 32'h5A5A_5A5A, 1'b1, '{32'h0, 7'd4, ST_DONE}},
    '{OP_INSERT,  6'd1,  32'h1234_5678, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OP_READ,    6'd0,  32'hFFFF_FFFF, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OP_READ,    6'd63, 32'h0000_0000, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OP_REPLACE, 6'd2,  32'h0F0F_F0F0, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OP_REPLACE, 6'd5,  32'h3C3C_C3C3, 1'b1, '{32'h0, 7'd5, ST_RANGE}},
    '{OP_REMOVE,  6'd0,  32'h0000_0000, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OP_REMOVE,  6'd63, 32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd4, ST_RANGE}},
    '{OP_READ,    6'd2,  32'h0000_0000, 1'b0, '{32'h0, 7'd0, ST_DONE}},
    '{OpSpare6,   6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd4, ST_DONE}},
    '{OpSpare7,   6'd63, 32'hFFFF_FFFF, 1'b1, '{32'h0, 7'd4, ST_DONE}},
    '{OP_CLEAR,   6'd0,  32'h0000_0000, 1'b1, '{32'h0, 7'd0, ST_DONE}},
    '{OP_READ,    6'd63, 32'h0000_0000, 1'b1, '{32'h0, 7'd0, ST_EMPTY}}
  };

  positional_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .item_data_i   (item_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Places a word at pos, shifting later entries up; past the end it appends.
  function automatic status_e store_at(int unsigned pos, logic [DataOutW-1:0] word);
    int unsigned i;
    if (list_count >= Depth) return ST_FULL;
    if (pos > list_count) pos = list_count;
    for (i = list_count; i > pos; i--) list_cells[i] = list_cells[i-1];
    list_cells[pos] = word;
    list_count++;
    return ST_DONE;
  endfunction

  function automatic list_result_t apply_operation(logic [2:0] op, logic [PosW-1:0] pos,
                                                   logic [DataOutW-1:0] word);
    list_result_t res;
    int unsigned  i;
    int unsigned  at;
    res = '{read_data: '0, entry_count: '0, status: ST_DONE};
    at  = pos;
    case (op)
      OP_APPEND:  res.status = store_at(list_count, word);
      OP_INSERT:  res.status = store_at(at, word);
      OP_REMOVE: begin
        if (at >= list_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = at; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
        end
      end
      OP_REPLACE: begin
        if (at >= list_count) res.status = ST_RANGE;
        else list_cells[at] = word;
      end
      OP_READ: begin
        // Past the end the position is clamped to the last entry.
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (at > list_count - 1) at = list_count - 1;
          res.read_data = list_cells[at];
        end
      end
      OP_CLEAR:   list_count = 0;
      default: ;
    endcase
    res.entry_count = list_count[CntOutW-1:0];
    return res;
  endfunction

  // Offers one beat after a random idle gap, none while steady is set, and records its expected result on acceptance.
  task automatic send_beat(logic [2:0] op, logic [PosW-1:0] pos, logic [DataOutW-1:0] word,
                           bit typed, list_result_t want);
    list_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    item_data_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_operation(op, pos, word);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_random(int unsigned beats);
    int unsigned         sent;
    int unsigned         round_left;
    int unsigned         roll;
    int unsigned         span;
    traffic_mode_e       mode;
    logic [2:0]          op;
    logic [PosW-1:0]     pos;
    logic [DataOutW-1:0] word;
    sent       = 0;
    mode       = FILL_MODE;
    round_left = 150;
    while (sent < beats) begin
      if (round_left == 0) begin
        roll       = $urandom_range(0, 2);
        mode       = (roll == 0) ? FILL_MODE : (roll == 1) ? DRAIN_MODE : MIX_MODE;
        round_left = $urandom_range(20, 100);
      end
      // Long receiver hold while the list is filling; a no-idle stretch later on.
      hold_req = (sent >= 40);
      steady   = (sent >= 300 && sent < 380);

      roll = $urandom_range(0, 99);
      case (mode)
        FILL_MODE:
          op = (roll < 45) ? OP_APPEND : (roll < 80) ? OP_INSERT : (roll < 88) ? OP_READ :
               (roll < 94) ? OP_REPLACE : (roll < 98) ? OP_REMOVE : OpSpare6;
        DRAIN_MODE:
          op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
               (roll < 80) ? OP_READ : (roll < 92) ? OP_REPLACE : (roll < 95) ? OP_CLEAR :
               OpSpare7;
        default:
          op = (roll < 20) ? OP_APPEND : (roll < 40) ? OP_INSERT : (roll < 58) ? OP_REMOVE :
               (roll < 72) ? OP_REPLACE : (roll < 90) ? OP_READ : (roll < 93) ? OP_CLEAR :
               (roll < 97) ? OpSpare6 : OpSpare7;
      endcase

      // Most positions land inside or just past the live part of the list.
      if ($urandom_range(0, 99) < 65) begin
        span = $urandom_range(0, list_count);
        pos  = (span > 63) ? 6'd63 : span[PosW-1:0];
      end else begin
        pos = PosW'($urandom_range(0, 63));
      end

      roll = $urandom_range(0, 99);
      word = (roll < 5) ? '0 : (roll < 10) ? '1 : $urandom;

      send_beat(op, pos, word, 1'b0, '{'0, '0, ST_DONE});
      sent++;
      round_left--;
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, one long hold so the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Result checker: every accepted result beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data) begin
          $error("read_data: expected %h, actual %h", want.read_data, read_data_o);
          mismatches++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("positional_list_engine verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned row;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < $size(directed_rows); row++) begin
      send_beat(directed_rows[row].op, directed_rows[row].pos, directed_rows[row].data,
                directed_rows[row].typed, directed_rows[row].want);
    end
    run_random(RandomBeats);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("positional_list_engine verification clean");
    end else begin
      $display("positional_list_engine verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
design/ple_checker.sv
tb/sv/tb_positional_list_engine.sv
